// ----- hw/rtl/clrq_pkg.sv -----
package clrq_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned SectorBits = 48;
  localparam int unsigned TagBits    = 8;

  // Request action codes.
  localparam logic ActAdd      = 1'b0;
  localparam logic ActDispatch = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_HOLD
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic add;
    logic dispatch;
  } cmd_t;

endpackage

// ----- hw/rtl/clrq_req_if.sv -----
interface clrq_req_if #(
  parameter int unsigned SECTOR_BITS = clrq_pkg::SectorBits,
  parameter int unsigned TAG_BITS    = clrq_pkg::TagBits
);
  logic                   valid;
  logic                   ready;
  logic                   action;
  logic [SECTOR_BITS-1:0] sector;
  logic [TAG_BITS-1:0]    tag;

  modport source (output valid, action, sector, tag, input ready);
  modport sink   (input valid, action, sector, tag, output ready);
  modport mon    (input valid, ready, action, sector, tag);
endinterface

// ----- hw/rtl/clrq_res_if.sv -----
interface clrq_res_if #(
  parameter int unsigned SECTOR_BITS = clrq_pkg::SectorBits,
  parameter int unsigned TAG_BITS    = clrq_pkg::TagBits,
  parameter int unsigned OCC_BITS    = $clog2(clrq_pkg::QueueDepth + 1)
);
  logic                   valid;
  logic                   ready;
  logic                   dispatched;
  logic [SECTOR_BITS-1:0] out_sector;
  logic [TAG_BITS-1:0]    out_tag;
  logic                   refused;
  logic [OCC_BITS-1:0]    occupancy;

  modport source (output valid, dispatched, out_sector, out_tag, refused, occupancy,
                  input ready);
  modport sink   (input valid, dispatched, out_sector, out_tag, refused, occupancy,
                  output ready);
  modport mon    (input valid, ready, dispatched, out_sector, out_tag, refused, occupancy);
endinterface

// ----- hw/rtl/clrq_ctrl.sv -----
module clrq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_action_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output clrq_pkg::cmd_t   cmd_o
);

  clrq_pkg::ctrl_state_e state_q, state_d;
  logic accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= clrq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    state_d     = state_q;
    unique case (state_q)
      clrq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      clrq_pkg::ST_HOLD: begin
        out_valid_o = 1'b1;
        // Take the next request in the cycle the held result drains.
        in_ready_o  = out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase

    accept = in_valid_i && in_ready_o;

    if (accept) begin
      state_d = clrq_pkg::ST_HOLD;
    end else if (state_q == clrq_pkg::ST_HOLD && out_ready_i) begin
      state_d = clrq_pkg::ST_IDLE;
    end

    cmd_o.load     = accept;
    cmd_o.add      = accept && (in_action_i == clrq_pkg::ActAdd);
    cmd_o.dispatch = accept && (in_action_i == clrq_pkg::ActDispatch);
  end

endmodule

// ----- hw/rtl/clrq_datapath.sv -----
module clrq_datapath #(
  parameter int unsigned QUEUE_DEPTH = clrq_pkg::QueueDepth,
  parameter int unsigned SECTOR_BITS = clrq_pkg::SectorBits,
  parameter int unsigned TAG_BITS    = clrq_pkg::TagBits,
  parameter int unsigned OCC_BITS    = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  clrq_pkg::cmd_t         cmd_i,
  input  logic [SECTOR_BITS-1:0] sector_i,
  input  logic [TAG_BITS-1:0]    tag_i,
  output logic                   dispatched_o,
  output logic [SECTOR_BITS-1:0] out_sector_o,
  output logic [TAG_BITS-1:0]    out_tag_o,
  output logic                   refused_o,
  output logic [OCC_BITS-1:0]    occupancy_o
);

  logic [SECTOR_BITS-1:0] sec_q [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]    tag_q [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] valid_q, valid_d;
  logic [OCC_BITS-1:0]    count_q, count_d;
  logic [SECTOR_BITS-1:0] head_q;

  logic [QUEUE_DEPTH-1:0] before_new; // entry stays ahead of the new request
  logic                   new_low;
  logic                   full, empty;
  logic                   do_add, do_disp;

  logic                   res_disp_q, res_ref_q;
  logic [SECTOR_BITS-1:0] res_sec_q;
  logic [TAG_BITS-1:0]    res_tag_q;
  logic [OCC_BITS-1:0]    res_occ_q;

  assign full    = (count_q == OCC_BITS'(QUEUE_DEPTH));
  assign empty   = (count_q == '0);
  assign do_add  = cmd_i.add && !full;
  assign do_disp = cmd_i.dispatch && !empty;
  assign new_low = (sector_i < head_q);

  // Each cell compares its entry with the broadcast request in C-LOOK order.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      logic e_low;
      e_low = (sec_q[i] < head_q);
      if (e_low != new_low) begin
        before_new[i] = valid_q[i] && !e_low;
      end else begin
        before_new[i] = valid_q[i] && (sec_q[i] <= sector_i);
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    if (do_add) begin
      valid_d = {valid_q[QUEUE_DEPTH-2:0], 1'b1};
      count_d = count_q + OCC_BITS'(1);
    end else if (do_disp) begin
      valid_d = valid_q >> 1;
      count_d = count_q - OCC_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      head_q  <= '1;
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
      if (do_disp) begin
        head_q <= sec_q[0];
      end
    end
  end

  // Entry cells: keep, take the new request, or shift.
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic prev_before;
    if (g == 0) begin : g_first
      assign prev_before = 1'b1;
    end else begin : g_rest
      assign prev_before = before_new[g-1];
    end

    always_ff @(posedge clk_i) begin
      if (do_add && !before_new[g]) begin
        if (prev_before) begin
          sec_q[g] <= sector_i;
          tag_q[g] <= tag_i;
        end else begin
          sec_q[g] <= sec_q[(g == 0) ? 0 : g-1];
          tag_q[g] <= tag_q[(g == 0) ? 0 : g-1];
        end
      end else if (do_disp && (g < QUEUE_DEPTH - 1)) begin
        sec_q[g] <= sec_q[(g < QUEUE_DEPTH - 1) ? g+1 : g];
        tag_q[g] <= tag_q[(g < QUEUE_DEPTH - 1) ? g+1 : g];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_disp_q <= do_disp;
      res_sec_q  <= do_disp ? sec_q[0] : '0;
      res_tag_q  <= do_disp ? tag_q[0] : '0;
      res_ref_q  <= cmd_i.add && full;
      res_occ_q  <= count_d;
    end
  end

  assign dispatched_o = res_disp_q;
  assign out_sector_o = res_sec_q;
  assign out_tag_o    = res_tag_q;
  assign refused_o    = res_ref_q;
  assign occupancy_o  = res_occ_q;

endmodule

// ----- hw/rtl/c_look_request_queue.sv -----
// A result is valid in the cycle after its request is accepted; every queue cell
// updates in parallel in the accept cycle. Throughput: one request per cycle
// while results drain; the result register frees as the downstream takes it.
// Reset (rst_ni low, asynchronous): queue empty, head position all ones,
//   no result pending.
module c_look_request_queue #(
  parameter int unsigned QUEUE_DEPTH = clrq_pkg::QueueDepth,
  parameter int unsigned SECTOR_BITS = clrq_pkg::SectorBits,
  parameter int unsigned TAG_BITS    = clrq_pkg::TagBits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  clrq_req_if.sink   req_i,
  clrq_res_if.source res_o
);

  localparam int unsigned OCC_BITS = $clog2(QUEUE_DEPTH + 1);

  clrq_pkg::cmd_t cmd;

  // Controller: owns the handshakes and turns an accepted request into
  // an add or dispatch command for the cells.
  clrq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_action_i (req_i.action),
    .in_ready_o  (req_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .cmd_o       (cmd)
  );

  // Datapath: the sorted row of entry cells, the head position, the fill
  // count and the result register. An add drops into its C-LOOK slot with
  // one compare per cell; a dispatch shifts the row toward the front.
  clrq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .SECTOR_BITS (SECTOR_BITS),
    .TAG_BITS    (TAG_BITS),
    .OCC_BITS    (OCC_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sector_i     (req_i.sector),
    .tag_i        (req_i.tag),
    .dispatched_o (res_o.dispatched),
    .out_sector_o (res_o.out_sector),
    .out_tag_o    (res_o.out_tag),
    .refused_o    (res_o.refused),
    .occupancy_o  (res_o.occupancy)
  );

endmodule

// ----- hw/rtl/clrq_checker.sv -----
module clrq_checker #(
  parameter int unsigned QUEUE_DEPTH = clrq_pkg::QueueDepth,
  parameter int unsigned SECTOR_BITS = clrq_pkg::SectorBits,
  parameter int unsigned TAG_BITS    = clrq_pkg::TagBits,
  parameter int unsigned OCC_BITS    = $clog2(QUEUE_DEPTH + 1)
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   req_valid_i,
  input logic                   req_ready_i,
  input logic                   res_valid_i,
  input logic                   res_ready_i,
  input logic                   res_dispatched_i,
  input logic [SECTOR_BITS-1:0] res_sector_i,
  input logic [TAG_BITS-1:0]    res_tag_i,
  input logic                   res_refused_i,
  input logic [OCC_BITS-1:0]    res_occupancy_i
);

  // Hold a stalled result.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_sector_i)
      && $stable(res_tag_i) && $stable(res_occupancy_i))
    else $error("stalled result changed");

  // A request is never both served and refused.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> !(res_dispatched_i && res_refused_i))
    else $error("dispatched and refused together");

  // Refuse only at full occupancy.
  a_refuse_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_refused_i |-> res_occupancy_i == OCC_BITS'(QUEUE_DEPTH))
    else $error("refused below full");

  // Drive zero sector and tag when nothing was dispatched.
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_dispatched_i |-> res_sector_i == '0 && res_tag_i == '0)
    else $error("nonzero fields without dispatch");

  // Raise a result the cycle after each accepted request.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> res_valid_i)
    else $error("no result after accepted request");

endmodule

bind c_look_request_queue clrq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH),
  .SECTOR_BITS (SECTOR_BITS),
  .TAG_BITS    (TAG_BITS)
) u_clrq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .res_dispatched_i (res_o.dispatched),
  .res_sector_i     (res_o.out_sector),
  .res_tag_i        (res_o.out_tag),
  .res_refused_i    (res_o.refused),
  .res_occupancy_i  (res_o.occupancy)
);
